FILE: hw/rtl/i2crts_pkg.sv
// shared types and codes for the i2c register transaction sequencer
package i2crts_pkg;

   localparam logic [2:0] OP_LOAD     = 3'd0;
   localparam logic [2:0] OP_START    = 3'd1;
   localparam logic [2:0] OP_TX_READY = 3'd2;
   localparam logic [2:0] OP_RX_BYTE  = 3'd3;
   localparam logic [2:0] OP_NACK     = 3'd4;
   localparam logic [2:0] OP_READ     = 3'd5;

   localparam logic [2:0] ACT_NONE          = 3'd0;
   localparam logic [2:0] ACT_SEND          = 3'd1;
   localparam logic [2:0] ACT_STOP          = 3'd2;
   localparam logic [2:0] ACT_RESTART_RX    = 3'd3;
   localparam logic [2:0] ACT_RESTART_RX_SP = 3'd4;
   localparam logic [2:0] ACT_START_TX      = 3'd5;

   localparam logic [1:0] KIND_RAW       = 2'd0;
   localparam logic [1:0] KIND_REG_WRITE = 2'd1;
   localparam logic [1:0] KIND_REG_READ  = 2'd2;

   localparam logic [1:0] STATUS_NONE   = 2'd0;
   localparam logic [1:0] STATUS_OK     = 2'd1;
   localparam logic [1:0] STATUS_NACK   = 2'd2;
   localparam logic [1:0] STATUS_REJECT = 2'd3;

   // address bits for the largest supported store
   localparam int ADDR_W = 8;

   typedef struct packed {
      logic [2:0] op;
      logic [6:0] target_address;
      logic [7:0] register_address;
      logic [1:0] kind;
      logic [7:0] length;
      logic [5:0] buffer_index;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] tx_byte;
      logic [6:0] bus_address;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] read_data;
   } result_type;

   typedef struct packed {
      logic              tx_we;
      logic              rx_we;
      logic [ADDR_W-1:0] tx_addr;
      logic [ADDR_W-1:0] rx_addr;
      logic [7:0]        data;
   } buf_wr_type;

endpackage

FILE: hw/rtl/i2crts_buffer.sv
// transmit and receive byte stores with registered reads and write bypass
module i2crts_buffer #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [i2crts_pkg::ADDR_W-1:0]  tx_raddr,
   input  logic [i2crts_pkg::ADDR_W-1:0]  rx_raddr,
   input  i2crts_pkg::buf_wr_type         wr,
   output logic [7:0]                     tx_rdata,
   output logic [7:0]                     rx_rdata
);

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   logic [7:0] tx_mem [BUFFER_DEPTH];
   logic [7:0] rx_mem [BUFFER_DEPTH];
   logic [7:0] tx_rdata_ff;
   logic [7:0] rx_rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.tx_we) begin
         tx_mem[wr.tx_addr[AW-1:0]] <= wr.data;
      end
      if (rd_en) begin
         if (wr.tx_we && (wr.tx_addr[AW-1:0] == tx_raddr[AW-1:0])) begin
            tx_rdata_ff <= wr.data;
         end else begin
            tx_rdata_ff <= tx_mem[tx_raddr[AW-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.rx_we) begin
         rx_mem[wr.rx_addr[AW-1:0]] <= wr.data;
      end
      if (rd_en) begin
         if (wr.rx_we && (wr.rx_addr[AW-1:0] == rx_raddr[AW-1:0])) begin
            rx_rdata_ff <= wr.data;
         end else begin
            rx_rdata_ff <= rx_mem[rx_raddr[AW-1:0]];
         end
      end
   end

   assign tx_rdata = tx_rdata_ff;
   assign rx_rdata = rx_rdata_ff;

endmodule

FILE: hw/rtl/i2crts_seq.sv
// transaction state and per-item bus action decode
module i2crts_seq #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  i2crts_pkg::item_type           item,
   input  logic [7:0]                     tx_rdata,
   input  logic [7:0]                     rx_rdata,
   output i2crts_pkg::result_type         result,
   output i2crts_pkg::buf_wr_type         wr,
   output logic [i2crts_pkg::ADDR_W-1:0]  tx_raddr
);

   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam logic [8:0] DEPTH_V = 9'(BUFFER_DEPTH);

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_NACK   = 3'd1;
   localparam logic [2:0] MODE_REG    = 3'd2;
   localparam logic [2:0] MODE_TXDATA = 3'd3;
   localparam logic [2:0] MODE_RXDATA = 3'd4;
   localparam logic [2:0] MODE_SWITCH = 3'd5;

   logic [2:0]    mode_ff, mode_in;
   logic [CW-1:0] tx_rem_ff, tx_rem_in;
   logic [CW-1:0] rx_rem_ff, rx_rem_in;
   logic [CW-1:0] tx_pos_ff, tx_pos_in;
   logic [CW-1:0] rx_pos_ff, rx_pos_in;
   logic [7:0]    held_reg_ff, held_reg_in;
   logic [6:0]    held_addr_ff, held_addr_in;

   logic          busy;
   logic          idx_ok;
   logic          bad_start;
   logic          kind_bad;
   logic [CW-1:0] rx_rem_new;

   assign busy = (mode_ff == MODE_REG) || (mode_ff == MODE_TXDATA) ||
                 (mode_ff == MODE_RXDATA) || (mode_ff == MODE_SWITCH);
   assign idx_ok = 9'(item.buffer_index) < DEPTH_V;
   assign kind_bad = (item.kind != i2crts_pkg::KIND_RAW) &&
                     (item.kind != i2crts_pkg::KIND_REG_WRITE) &&
                     (item.kind != i2crts_pkg::KIND_REG_READ);
   assign bad_start = kind_bad || ({1'b0, item.length} > DEPTH_V) ||
                      ((item.length == 8'd0) && (item.kind != i2crts_pkg::KIND_REG_WRITE));
   assign rx_rem_new = (rx_rem_ff != '0) ? rx_rem_ff - CW'(1) : rx_rem_ff;

   always_comb begin
      mode_in      = mode_ff;
      tx_rem_in    = tx_rem_ff;
      rx_rem_in    = rx_rem_ff;
      tx_pos_in    = tx_pos_ff;
      rx_pos_in    = rx_pos_ff;
      held_reg_in  = held_reg_ff;
      held_addr_in = held_addr_ff;
      result       = '0;
      wr           = '0;
      wr.data      = item.data_byte;
      wr.tx_addr   = i2crts_pkg::ADDR_W'(item.buffer_index);
      wr.rx_addr   = i2crts_pkg::ADDR_W'(rx_pos_ff);
      unique case (item.op)
         i2crts_pkg::OP_LOAD: begin
            if (busy) begin
               result.status = i2crts_pkg::STATUS_REJECT;
            end else begin
               wr.tx_we = advance && idx_ok;
            end
         end
         i2crts_pkg::OP_START: begin
            if (busy) begin
               result.status = i2crts_pkg::STATUS_REJECT;
            end else if (bad_start) begin
               result.status   = i2crts_pkg::STATUS_REJECT;
               result.done_res = 1'b1;
            end else begin
               held_addr_in = item.target_address;
               held_reg_in  = item.register_address;
               tx_pos_in    = '0;
               rx_pos_in    = '0;
               if (item.kind == i2crts_pkg::KIND_REG_READ) begin
                  tx_rem_in = '0;
                  rx_rem_in = CW'(item.length);
               end else begin
                  tx_rem_in = CW'(item.length);
                  rx_rem_in = '0;
               end
               mode_in = (item.kind == i2crts_pkg::KIND_RAW) ? MODE_TXDATA : MODE_REG;
               result.action      = i2crts_pkg::ACT_START_TX;
               result.bus_address = item.target_address;
            end
         end
         i2crts_pkg::OP_TX_READY: begin
            if (mode_ff == MODE_REG) begin
               result.action  = i2crts_pkg::ACT_SEND;
               result.tx_byte = held_reg_ff;
               mode_in = (rx_rem_ff != '0) ? MODE_SWITCH : MODE_TXDATA;
            end else if (mode_ff == MODE_SWITCH) begin
               mode_in = MODE_RXDATA;
               result.action = (rx_rem_ff == CW'(1)) ? i2crts_pkg::ACT_RESTART_RX_SP
                                                     : i2crts_pkg::ACT_RESTART_RX;
               result.bus_address = held_addr_ff;
            end else if (mode_ff == MODE_TXDATA) begin
               if (tx_rem_ff != '0) begin
                  result.action  = i2crts_pkg::ACT_SEND;
                  result.tx_byte = (9'(tx_pos_ff) < DEPTH_V) ? tx_rdata : 8'd0;
                  tx_pos_in = tx_pos_ff + CW'(1);
                  tx_rem_in = tx_rem_ff - CW'(1);
               end else begin
                  result.action   = i2crts_pkg::ACT_STOP;
                  result.done_res = 1'b1;
                  result.status   = i2crts_pkg::STATUS_OK;
                  mode_in = MODE_IDLE;
               end
            end
         end
         i2crts_pkg::OP_RX_BYTE: begin
            if (mode_ff == MODE_RXDATA) begin
               if (rx_rem_ff != '0) begin
                  wr.rx_we  = advance && (9'(rx_pos_ff) < DEPTH_V);
                  rx_pos_in = rx_pos_ff + CW'(1);
                  rx_rem_in = rx_rem_new;
               end
               if (rx_rem_new == CW'(1)) begin
                  result.action = i2crts_pkg::ACT_STOP;
               end else if (rx_rem_new == '0) begin
                  result.done_res = 1'b1;
                  result.status   = i2crts_pkg::STATUS_OK;
                  mode_in = MODE_IDLE;
               end
            end
         end
         i2crts_pkg::OP_NACK: begin
            if (busy) begin
               result.action   = i2crts_pkg::ACT_STOP;
               result.done_res = 1'b1;
               result.status   = i2crts_pkg::STATUS_NACK;
               mode_in = MODE_NACK;
            end
         end
         i2crts_pkg::OP_READ: begin
            result.read_data = idx_ok ? rx_rdata : 8'd0;
         end
         default: begin
         end
      endcase
   end

   // read address for the next accepted item follows the updated position
   assign tx_raddr = i2crts_pkg::ADDR_W'(advance ? tx_pos_in : tx_pos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         tx_rem_ff    <= '0;
         rx_rem_ff    <= '0;
         tx_pos_ff    <= '0;
         rx_pos_ff    <= '0;
         held_reg_ff  <= '0;
         held_addr_ff <= '0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         tx_rem_ff    <= tx_rem_in;
         rx_rem_ff    <= rx_rem_in;
         tx_pos_ff    <= tx_pos_in;
         rx_pos_ff    <= rx_pos_in;
         held_reg_ff  <= held_reg_in;
         held_addr_ff <= held_addr_in;
      end
   end

endmodule

FILE: hw/rtl/i2c_register_transaction_sequencer.sv
// top level of the i2c register transaction sequencer
// Takes one request transfer per clock unless the response side stalls, and returns exactly
// one response transfer for each: the request is held in an input register, the sequencer
// state and the bus action are worked out in one pass, and the response waits in an output
// register, so a stalled response still lets one more request into an empty input register.
// Throughput is one item per cycle while responses flow, set by the sequencer state update;
// the transmit and receive stores are memories read once per accepted request.
module i2c_register_transaction_sequencer #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // target_address, register_address, kind, length, buffer_index, data_byte, zero pad
   input  logic [39:0] req_tdata,
   // op
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tx_byte, bus_address, status, read_data, zero pad
   output logic [31:0] rsp_tdata,
   // action
   output logic [2:0]  rsp_tuser,
   // done_res
   output logic        rsp_tlast
);

   i2crts_pkg::item_type   in_item;
   i2crts_pkg::item_type   s1_item_ff;
   logic                   s1_valid_ff;
   logic                   s1_adv;
   logic                   req_fire;
   i2crts_pkg::result_type seq_result;
   i2crts_pkg::result_type rsp_ff;
   logic                   rsp_valid_ff;
   i2crts_pkg::buf_wr_type buf_wr;
   logic [i2crts_pkg::ADDR_W-1:0] tx_raddr;
   logic [7:0]             tx_rdata;
   logic [7:0]             rx_rdata;

   assign in_item.op               = req_tuser;
   assign in_item.target_address   = req_tdata[6:0];
   assign in_item.register_address = req_tdata[14:7];
   assign in_item.kind             = req_tdata[16:15];
   assign in_item.length           = req_tdata[24:17];
   assign in_item.buffer_index     = req_tdata[30:25];
   assign in_item.data_byte        = req_tdata[38:31];

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= in_item;
      end
   end

   i2crts_buffer #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_buffer (
      .clock    (clock),
      .rd_en    (req_fire),
      .tx_raddr (tx_raddr),
      .rx_raddr (i2crts_pkg::ADDR_W'(in_item.buffer_index)),
      .wr       (buf_wr),
      .tx_rdata (tx_rdata),
      .rx_rdata (rx_rdata)
   );

   i2crts_seq #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .advance  (s1_adv),
      .item     (s1_item_ff),
      .tx_rdata (tx_rdata),
      .rx_rdata (rx_rdata),
      .result   (seq_result),
      .wr       (buf_wr),
      .tx_raddr (tx_raddr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_ff <= seq_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.action;
   assign rsp_tlast  = rsp_ff.done_res;
   assign rsp_tdata  = {7'd0, rsp_ff.read_data, rsp_ff.status, rsp_ff.bus_address,
                        rsp_ff.tx_byte};

endmodule

FILE: tb/sv/tb_i2c_register_transaction_sequencer.sv
// self-checking testbench for the i2c register transaction sequencer
module tb_i2c_register_transaction_sequencer;

   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;
   localparam logic [1:0] KIND_BAD  = 2'd3;
   localparam int STORE_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 556;
   localparam int IDLE_LIMIT   = 1000;

   localparam logic [2:0] SEQ_IDLE   = 3'd0;
   localparam logic [2:0] SEQ_NACK   = 3'd1;
   localparam logic [2:0] SEQ_REG    = 3'd2;
   localparam logic [2:0] SEQ_TXDATA = 3'd3;
   localparam logic [2:0] SEQ_RXDATA = 3'd4;
   localparam logic [2:0] SEQ_SWITCH = 3'd5;

   typedef struct {
      i2crts_pkg::item_type   it;
      bit                     typed;
      i2crts_pkg::result_type want;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   i2c_register_transaction_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // sequencer shadow state
   logic [2:0]  seq_mode;
   logic [7:0]  tx_mem [STORE_DEPTH];
   logic [7:0]  rx_mem [STORE_DEPTH];
   bit          rx_written [STORE_DEPTH];
   int unsigned tx_left, rx_left, tx_ptr, rx_ptr;
   logic [7:0]  reg_hold;
   logic [6:0]  addr_hold;

   i2crts_pkg::result_type expected_rsp [$];
   table_row_type          directed_rows [$];
   i2crts_pkg::item_type   req_item;
   bit                     req_typed = 1'b0;
   i2crts_pkg::result_type req_want;
   bit          steady = 1'b0;
   int          errors = 0;
   int          idle_cycles = 0;
   int          n_ok = 0, n_nack = 0, n_reject = 0, n_reads = 0, n_items = 0, n_noise = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit seq_busy();
      return seq_mode inside {SEQ_REG, SEQ_TXDATA, SEQ_RXDATA, SEQ_SWITCH};
   endfunction

   function automatic i2crts_pkg::result_type predict_step(i2crts_pkg::item_type it);
      i2crts_pkg::result_type r;
      r = '0;
      case (it.op)
         i2crts_pkg::OP_LOAD: begin
            if (seq_busy()) r.status = i2crts_pkg::STATUS_REJECT;
            else tx_mem[it.buffer_index] = it.data_byte;
         end
         i2crts_pkg::OP_START: begin
            if (seq_busy()) begin
               r.status = i2crts_pkg::STATUS_REJECT;
            end else if (it.kind == KIND_BAD || it.length > STORE_DEPTH ||
                         (it.length == 0 && it.kind != i2crts_pkg::KIND_REG_WRITE)) begin
               r.status   = i2crts_pkg::STATUS_REJECT;
               r.done_res = 1'b1;
            end else begin
               addr_hold     = it.target_address;
               reg_hold      = it.register_address;
               tx_ptr        = 0;
               rx_ptr        = 0;
               tx_left       = (it.kind == i2crts_pkg::KIND_REG_READ) ? 0 : it.length;
               rx_left       = (it.kind == i2crts_pkg::KIND_REG_READ) ? it.length : 0;
               seq_mode      = (it.kind == i2crts_pkg::KIND_RAW) ? SEQ_TXDATA : SEQ_REG;
               r.action      = i2crts_pkg::ACT_START_TX;
               r.bus_address = it.target_address;
            end
         end
         i2crts_pkg::OP_TX_READY: begin
            if (seq_mode == SEQ_REG) begin
               r.action = i2crts_pkg::ACT_SEND;
               r.tx_byte = reg_hold;
               seq_mode = (rx_left != 0) ? SEQ_SWITCH : SEQ_TXDATA;
            end else if (seq_mode == SEQ_SWITCH) begin
               seq_mode      = SEQ_RXDATA;
               r.action      = (rx_left == 1) ? i2crts_pkg::ACT_RESTART_RX_SP
                                              : i2crts_pkg::ACT_RESTART_RX;
               r.bus_address = addr_hold;
            end else if (seq_mode == SEQ_TXDATA) begin
               if (tx_left != 0) begin
                  r.action = i2crts_pkg::ACT_SEND;
                  if (tx_ptr < STORE_DEPTH) r.tx_byte = tx_mem[tx_ptr];
                  tx_ptr++;
                  tx_left--;
               end else begin
                  r.action   = i2crts_pkg::ACT_STOP;
                  seq_mode   = SEQ_IDLE;
                  r.done_res = 1'b1;
                  r.status   = i2crts_pkg::STATUS_OK;
               end
            end
         end
         i2crts_pkg::OP_RX_BYTE: begin
            if (seq_mode == SEQ_RXDATA) begin
               if (rx_left != 0) begin
                  if (rx_ptr < STORE_DEPTH) begin
                     rx_mem[rx_ptr]     = it.data_byte;
                     rx_written[rx_ptr] = 1'b1;
                  end
                  rx_ptr++;
                  rx_left--;
               end
               if (rx_left == 1) begin
                  r.action = i2crts_pkg::ACT_STOP;
               end else if (rx_left == 0) begin
                  seq_mode   = SEQ_IDLE;
                  r.done_res = 1'b1;
                  r.status   = i2crts_pkg::STATUS_OK;
               end
            end
         end
         i2crts_pkg::OP_NACK: begin
            if (seq_busy()) begin
               r.action   = i2crts_pkg::ACT_STOP;
               seq_mode   = SEQ_NACK;
               r.done_res = 1'b1;
               r.status   = i2crts_pkg::STATUS_NACK;
            end
         end
         i2crts_pkg::OP_READ: r.read_data = rx_mem[it.buffer_index];
         default: ;
      endcase
      return r;
   endfunction

   function automatic i2crts_pkg::item_type mk_item(logic [2:0] op, logic [6:0] taddr,
                                                    logic [7:0] regaddr, logic [1:0] kind,
                                                    logic [7:0] len, logic [5:0] idx,
                                                    logic [7:0] data);
      i2crts_pkg::item_type it;
      it = '{op, taddr, regaddr, kind, len, idx, data};
      return it;
   endfunction

   function automatic i2crts_pkg::result_type mk_rsp(logic [2:0] act, logic [7:0] txb,
                                                     logic [6:0] baddr, logic done,
                                                     logic [1:0] status, logic [7:0] rdata);
      i2crts_pkg::result_type r;
      r = '{act, txb, baddr, done, status, rdata};
      return r;
   endfunction

   function automatic void add_row(i2crts_pkg::item_type it, bit typed,
                                   i2crts_pkg::result_type want);
      table_row_type row;
      row.it    = it;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   // random item shaped by the current sequencer mode; counted is 0 for pure noise
   task automatic pick_item(output i2crts_pkg::item_type it, output bit counted);
      logic [63:0] raw;
      int          r, start_idx;
      bit          found;
      raw     = {$urandom, $urandom};
      it      = raw[41:0];
      counted = 1'b1;
      r       = $urandom_range(0, 99);
      if (!seq_busy()) begin
         if (r < 55) begin
            it.op   = i2crts_pkg::OP_START;
            it.kind = 2'($urandom_range(0, 2));
            case ($urandom_range(0, 19))
               0:       it.length = 8'(STORE_DEPTH);
               1, 2:    it.length = 8'($urandom_range(9, 63));
               3:       it.length = (it.kind == i2crts_pkg::KIND_REG_WRITE) ? 8'd0 : 8'd1;
               default: it.length = 8'($urandom_range(1, 6));
            endcase
         end else if (r < 65) begin
            it.op = i2crts_pkg::OP_START;
            case ($urandom_range(0, 2))
               0:       it.kind = KIND_BAD;
               1: begin
                  it.length = 8'($urandom_range(STORE_DEPTH + 1, 255));
               end
               default: begin
                  it.kind   = ($urandom_range(0, 1) != 0) ? i2crts_pkg::KIND_RAW
                                                          : i2crts_pkg::KIND_REG_READ;
                  it.length = 8'd0;
               end
            endcase
         end else if (r < 80) begin
            it.op = i2crts_pkg::OP_LOAD;
         end else if (r < 90) begin
            it.op = i2crts_pkg::OP_READ;
         end else begin
            counted = 1'b0;
            case ($urandom_range(0, 4))
               0: it.op = i2crts_pkg::OP_TX_READY;
               1: it.op = i2crts_pkg::OP_RX_BYTE;
               2: it.op = i2crts_pkg::OP_NACK;
               3: it.op = OP_SPARE6;
               default: it.op = OP_SPARE7;
            endcase
         end
      end else if (seq_mode == SEQ_RXDATA) begin
         if (r < 80) it.op = i2crts_pkg::OP_RX_BYTE;
         else if (r < 84) it.op = i2crts_pkg::OP_NACK;
         else if (r < 89) it.op = i2crts_pkg::OP_START;
         else if (r < 94) it.op = i2crts_pkg::OP_READ;
         else begin
            it.op   = ($urandom_range(0, 1) != 0) ? i2crts_pkg::OP_TX_READY : OP_SPARE7;
            counted = 1'b0;
         end
      end else begin
         if (r < 80) it.op = i2crts_pkg::OP_TX_READY;
         else if (r < 85) it.op = i2crts_pkg::OP_NACK;
         else if (r < 90) it.op = i2crts_pkg::OP_START;
         else if (r < 95) it.op = i2crts_pkg::OP_LOAD;
         else begin
            it.op   = ($urandom_range(0, 1) != 0) ? i2crts_pkg::OP_RX_BYTE : OP_SPARE6;
            counted = 1'b0;
         end
      end
      if (it.op == i2crts_pkg::OP_READ) begin
         found     = 1'b0;
         start_idx = $urandom_range(0, STORE_DEPTH - 1);
         for (int k = 0; k < STORE_DEPTH && !found; k++) begin
            if (rx_written[(start_idx + k) % STORE_DEPTH]) begin
               it.buffer_index = 6'((start_idx + k) % STORE_DEPTH);
               found = 1'b1;
            end
         end
         if (!found) begin
            it.op   = OP_SPARE6;
            counted = 1'b0;
         end
      end
   endtask

   // drives one request transfer and waits until it is accepted; call just after a falling edge
   task automatic send_item(input i2crts_pkg::item_type it, input bit typed,
                            input i2crts_pkg::result_type want);
      req_item   <= it;
      req_typed  <= typed;
      req_want   <= want;
      req_tdata  <= {1'b0, it.data_byte, it.buffer_index, it.length, it.kind,
                     it.register_address, it.target_address};
      req_tuser  <= it.op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_gap();
      int gap;
      gap = steady ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
   endtask

   // request side: predict each accepted transfer
   always @(posedge clock) begin
      i2crts_pkg::result_type p;
      if (!reset && req_tvalid && req_tready) begin
         p = predict_step(req_item);
         expected_rsp.push_back(req_typed ? req_want : p);
      end
   end

   // response side: compare with the oldest expectation
   always @(posedge clock) begin
      i2crts_pkg::result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            $error("response transfer with no expectation waiting");
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_tuser !== e.action) begin
               $error("action: expected %0d, actual %0d", e.action, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[7:0] !== e.tx_byte) begin
               $error("tx_byte: expected %0h, actual %0h", e.tx_byte, rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tdata[14:8] !== e.bus_address) begin
               $error("bus_address: expected %0h, actual %0h", e.bus_address, rsp_tdata[14:8]);
               errors++;
            end
            if (rsp_tlast !== e.done_res) begin
               $error("done_res: expected %0d, actual %0d", e.done_res, rsp_tlast);
               errors++;
            end
            if (rsp_tdata[16:15] !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_tdata[16:15]);
               errors++;
            end
            if (rsp_tdata[24:17] !== e.read_data) begin
               $error("read_data: expected %0h, actual %0h", e.read_data, rsp_tdata[24:17]);
               errors++;
            end
            if (rsp_tdata[31:25] !== 7'd0) begin
               $error("pad: expected 0, actual %0h", rsp_tdata[31:25]);
               errors++;
            end
            if (e.done_res && e.status == i2crts_pkg::STATUS_OK) n_ok++;
            if (e.status == i2crts_pkg::STATUS_NACK) n_nack++;
            if (e.status == i2crts_pkg::STATUS_REJECT) n_reject++;
         end
      end
   end

   // response side backpressure
   initial begin
      int stall;
      forever begin
         stall = steady ? 0 : $urandom_range(0, 11);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      i2crts_pkg::item_type   it;
      i2crts_pkg::result_type none;
      bit                     counted;
      none     = '0;
      seq_mode = SEQ_IDLE;
      tx_left  = 0;
      rx_left  = 0;
      tx_ptr   = 0;
      rx_ptr   = 0;
      reg_hold  = '0;
      addr_hold = '0;
      foreach (rx_written[k]) begin
         rx_written[k] = 1'b0;
         rx_mem[k]     = '0;
         tx_mem[k]     = '0;
      end

      // rejects and ignored items
      add_row(mk_item(i2crts_pkg::OP_START, 7'h12, 8'h34, KIND_BAD, 8'd5, 6'd0, 8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_NONE, 8'h00, 7'h00, 1'b1, i2crts_pkg::STATUS_REJECT,
                     8'h00));
      add_row(mk_item(i2crts_pkg::OP_START, 7'h7F, 8'hFF, i2crts_pkg::KIND_RAW, 8'd0, 6'd0,
                      8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_NONE, 8'h00, 7'h00, 1'b1, i2crts_pkg::STATUS_REJECT,
                     8'h00));
      add_row(mk_item(i2crts_pkg::OP_START, 7'h55, 8'hAA, i2crts_pkg::KIND_RAW, 8'd65, 6'd0,
                      8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_NONE, 8'h00, 7'h00, 1'b1, i2crts_pkg::STATUS_REJECT,
                     8'h00));
      add_row(mk_item(i2crts_pkg::OP_START, 7'h2A, 8'h55, i2crts_pkg::KIND_REG_WRITE, 8'd255,
                      6'd0, 8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_NONE, 8'h00, 7'h00, 1'b1, i2crts_pkg::STATUS_REJECT,
                     8'h00));
      add_row(mk_item(i2crts_pkg::OP_TX_READY, 7'h7F, 8'hFF, KIND_BAD, 8'hFF, 6'h3F, 8'hFF),
              1'b1, none);
      add_row(mk_item(i2crts_pkg::OP_RX_BYTE, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'h00, 6'h00,
                      8'hFF), 1'b1, none);
      add_row(mk_item(i2crts_pkg::OP_NACK, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'h00, 6'h00,
                      8'h00), 1'b1, none);
      add_row(mk_item(OP_SPARE6, 7'h7F, 8'hFF, KIND_BAD, 8'hFF, 6'h3F, 8'hFF), 1'b1, none);
      add_row(mk_item(OP_SPARE7, 7'h7F, 8'hFF, KIND_BAD, 8'hFF, 6'h3F, 8'hFF), 1'b1, none);
      // register write of length zero, then a load of the last transmit entry
      add_row(mk_item(i2crts_pkg::OP_START, 7'h7F, 8'hFF, i2crts_pkg::KIND_REG_WRITE, 8'd0,
                      6'd0, 8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_START_TX, 8'h00, 7'h7F, 1'b0, i2crts_pkg::STATUS_NONE,
                     8'h00));
      add_row(mk_item(i2crts_pkg::OP_TX_READY, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'd0, 6'd0,
                      8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_SEND, 8'hFF, 7'h00, 1'b0, i2crts_pkg::STATUS_NONE, 8'h00));
      add_row(mk_item(i2crts_pkg::OP_TX_READY, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'd0, 6'd0,
                      8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_STOP, 8'h00, 7'h00, 1'b1, i2crts_pkg::STATUS_OK, 8'h00));
      add_row(mk_item(i2crts_pkg::OP_LOAD, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'd0, 6'h3F,
                      8'hFF), 1'b1, none);
      // raw write with start and load while busy
      add_row(mk_item(i2crts_pkg::OP_START, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'd1, 6'd0,
                      8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_START_TX, 8'h00, 7'h00, 1'b0, i2crts_pkg::STATUS_NONE,
                     8'h00));
      add_row(mk_item(i2crts_pkg::OP_START, 7'h11, 8'h22, i2crts_pkg::KIND_RAW, 8'd3, 6'd0,
                      8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_NONE, 8'h00, 7'h00, 1'b0, i2crts_pkg::STATUS_REJECT,
                     8'h00));
      add_row(mk_item(i2crts_pkg::OP_LOAD, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'd0, 6'd5,
                      8'hA5), 1'b1,
              mk_rsp(i2crts_pkg::ACT_NONE, 8'h00, 7'h00, 1'b0, i2crts_pkg::STATUS_REJECT,
                     8'h00));
      add_row(mk_item(i2crts_pkg::OP_TX_READY, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'd0, 6'd0,
                      8'h00), 1'b0, none);
      add_row(mk_item(i2crts_pkg::OP_TX_READY, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'd0, 6'd0,
                      8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_STOP, 8'h00, 7'h00, 1'b1, i2crts_pkg::STATUS_OK, 8'h00));
      // single-byte register read
      add_row(mk_item(i2crts_pkg::OP_START, 7'h55, 8'h00, i2crts_pkg::KIND_REG_READ, 8'd1,
                      6'd0, 8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_START_TX, 8'h00, 7'h55, 1'b0, i2crts_pkg::STATUS_NONE,
                     8'h00));
      add_row(mk_item(i2crts_pkg::OP_TX_READY, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'd0, 6'd0,
                      8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_SEND, 8'h00, 7'h00, 1'b0, i2crts_pkg::STATUS_NONE, 8'h00));
      add_row(mk_item(i2crts_pkg::OP_TX_READY, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'd0, 6'd0,
                      8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_RESTART_RX_SP, 8'h00, 7'h55, 1'b0,
                     i2crts_pkg::STATUS_NONE, 8'h00));
      add_row(mk_item(i2crts_pkg::OP_RX_BYTE, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'd0, 6'd0,
                      8'hFF), 1'b1,
              mk_rsp(i2crts_pkg::ACT_NONE, 8'h00, 7'h00, 1'b1, i2crts_pkg::STATUS_OK, 8'h00));
      add_row(mk_item(i2crts_pkg::OP_READ, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'd0, 6'd0,
                      8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_NONE, 8'h00, 7'h00, 1'b0, i2crts_pkg::STATUS_NONE, 8'hFF));
      // two-byte register read ended by nack
      add_row(mk_item(i2crts_pkg::OP_START, 7'h33, 8'h81, i2crts_pkg::KIND_REG_READ, 8'd2,
                      6'd0, 8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_START_TX, 8'h00, 7'h33, 1'b0, i2crts_pkg::STATUS_NONE,
                     8'h00));
      add_row(mk_item(i2crts_pkg::OP_TX_READY, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'd0, 6'd0,
                      8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_SEND, 8'h81, 7'h00, 1'b0, i2crts_pkg::STATUS_NONE, 8'h00));
      add_row(mk_item(i2crts_pkg::OP_TX_READY, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'd0, 6'd0,
                      8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_RESTART_RX, 8'h00, 7'h33, 1'b0, i2crts_pkg::STATUS_NONE,
                     8'h00));
      add_row(mk_item(i2crts_pkg::OP_RX_BYTE, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'd0, 6'd0,
                      8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_STOP, 8'h00, 7'h00, 1'b0, i2crts_pkg::STATUS_NONE, 8'h00));
      add_row(mk_item(i2crts_pkg::OP_NACK, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'd0, 6'd0,
                      8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_STOP, 8'h00, 7'h00, 1'b1, i2crts_pkg::STATUS_NACK, 8'h00));
      add_row(mk_item(i2crts_pkg::OP_READ, 7'h00, 8'h00, i2crts_pkg::KIND_RAW, 8'd0, 6'd0,
                      8'h00), 1'b1,
              mk_rsp(i2crts_pkg::ACT_NONE, 8'h00, 7'h00, 1'b0, i2crts_pkg::STATUS_NONE, 8'h00));
      // start from the nack state
      add_row(mk_item(i2crts_pkg::OP_START, 7'h01, 8'h02, i2crts_pkg::KIND_REG_WRITE, 8'd64,
                      6'd0, 8'h00), 1'b0, none);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill the whole transmit store before any transmit reads it
      for (int k = 0; k < STORE_DEPTH; k++) begin
         idle_gap();
         it = mk_item(i2crts_pkg::OP_LOAD, 7'($urandom), 8'($urandom), 2'($urandom),
                      8'($urandom), 6'(k), 8'($urandom));
         send_item(it, 1'b0, none);
      end

      foreach (directed_rows[k]) begin
         idle_gap();
         send_item(directed_rows[k].it, directed_rows[k].typed, directed_rows[k].want);
      end
      drain_results();

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         steady = ((k / 60) % 5) == 4;
         if (k % 150 == 75) drain_results();
         idle_gap();
         pick_item(it, counted);
         if (counted) n_items++;
         else n_noise++;
         if (it.op == i2crts_pkg::OP_READ) n_reads++;
         send_item(it, 1'b0, none);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("after store fill and directed table: %0d random items, %0d out-of-mode noise,",
               n_items, n_noise);
      $display("%0d transactions completed, %0d ended by nack, %0d rejected, %0d store reads",
               n_ok, n_nack, n_reject, n_reads);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
